/* src/csdp_pkg.sv */
// Shared types for the sums-of-distinct-powers counter: digit classes, FSM states, cmd/status.
package csdp_pkg;

  // Class of one base-B digit; the digit walk only needs zero, one or more
  typedef enum logic [1:0] {
    DIG_ZERO,
    DIG_ONE,
    DIG_BIG
  } dig_cls_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_DRAIN,
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DIGIT,
    ST_WALK_RD,
    ST_WALK_ADD,
    ST_PASS_END,
    ST_FIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic fill_step;   // issue one Pascal table entry
    logic latch_in;    // capture the input word
    logic start_pass;  // clear digit count and sum, reload power count
    logic div_load;    // start a new division of n by base
    logic div_step;    // one restoring division step
    logic push_digit;  // store the remainder's class as the next digit
    logic walk_issue;  // read the binomial for the top digit
    logic walk_add;    // add the binomial; drop the top digit unless the count ends
    logic pass_end;    // close one bound's count
    logic out_load;    // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fill_last;   // last table entry is being issued
    logic base_small;  // base below two, every count is zero
    logic div_last;    // current division step is the last one
    logic more_digits; // quotient nonzero and digit store not full
    logic walk_done;   // no digits or no powers left
    logic take;        // last walk step ends the count
    logic out_busy;    // output register full and not taken this cycle
    logic pass_lower;  // working on the lower bound
  } stat_t;

endpackage

/* src/csdp_if.sv */
// Valid/ready channel interfaces for query words and count words.
interface csdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] low_bound;
  logic [31:0] high_bound;
  logic [5:0]  power_count;
  logic [31:0] base;

  modport source (output valid, low_bound, high_bound, power_count, base, input ready);
  modport sink   (input valid, low_bound, high_bound, power_count, base, output ready);
endinterface

interface csdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

/* src/csdp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1296
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/csdp_ctrl.sv */
// Controller FSM: table fill, digit expansion, digit walk, two passes per query.
module csdp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  csdp_pkg::stat_t stat_i,
  output csdp_pkg::cmd_t  cmd_o
);
  import csdp_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL:     if (stat_i.fill_last) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_START;
      ST_START:    state_d = stat_i.base_small ? ST_PASS_END : ST_DIV;
      ST_DIV:      if (stat_i.div_last) state_d = ST_DIGIT;
      ST_DIGIT:    state_d = stat_i.more_digits ? ST_DIV : ST_WALK_RD;
      ST_WALK_RD:  state_d = stat_i.walk_done ? ST_PASS_END : ST_WALK_ADD;
      ST_WALK_ADD: state_d = stat_i.take ? ST_PASS_END : ST_WALK_RD;
      ST_PASS_END: state_d = stat_i.pass_lower ? ST_FIN : ST_START;
      ST_FIN:      if (!stat_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_FILL;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_FILL:     cmd_o.fill_step = 1'b1;
      ST_DRAIN:    ;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      ST_START: begin
        cmd_o.start_pass = 1'b1;
        cmd_o.div_load   = !stat_i.base_small;
      end
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_DIGIT: begin
        cmd_o.push_digit = 1'b1;
        cmd_o.div_load   = stat_i.more_digits;
      end
      ST_WALK_RD:  cmd_o.walk_issue = !stat_i.walk_done;
      ST_WALK_ADD: cmd_o.walk_add = 1'b1;
      ST_PASS_END: cmd_o.pass_end = 1'b1;
      ST_FIN:      cmd_o.out_load = !stat_i.out_busy;
      default:     ;
    endcase
  end

endmodule

/* src/csdp_dpath.sv */
// Datapath: Pascal table RAM, serial divider, digit class store, walk accumulator, output reg.
module csdp_dpath #(
  parameter int MAX_DIGITS = 32,
  parameter int TABLE_ROWS = 36
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  csdp_pkg::cmd_t  cmd_i,
  output csdp_pkg::stat_t stat_o,
  input  logic [31:0]     low_bound_i,
  input  logic [31:0]     high_bound_i,
  input  logic [5:0]      power_count_i,
  input  logic [31:0]     base_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [31:0]     out_count_o
);
  import csdp_pkg::*;

  localparam int MW    = $clog2(MAX_DIGITS + 1);
  localparam int RW    = $clog2(TABLE_ROWS);
  localparam int DEPTH = TABLE_ROWS * TABLE_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // Query operands
  logic [31:0] lo_q, base_q;
  logic [5:0]  kin_q;
  logic        pass_q;

  // Divider: n_q holds dividend, then quotient
  logic [31:0] n_q, rem_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_sh;
  logic        ge;

  // Digit store and walk state
  dig_cls_e    cls_q [MAX_DIGITS];
  dig_cls_e    new_cls, top_cls;
  logic [MW-1:0] m_q, mm;
  logic [5:0]  k_q;
  logic [31:0] acc_q, upper_q;
  logic        take, ok;
  logic        take_q, one_q, ok_q;

  // Table fill
  logic [RW-1:0] fill_row_q, fill_col_q;
  logic [RW-1:0] wr_row_q, wr_col_q;
  logic          wr_en_q;
  logic [31:0]   prev_q, wdata;
  logic [AW-1:0] fill_raddr, walk_raddr, raddr, waddr;
  logic [31:0]   rdata;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_count_q;

  // Pascal table, row-major
  csdp_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (wr_en_q),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Fill: entry (i,j) = T[i-1][j] + T[i-1][j-1]; row zero is a one then zeros
  assign fill_raddr = AW'(fill_row_q) * AW'(TABLE_ROWS) + AW'(fill_col_q) - AW'(TABLE_ROWS);
  assign waddr      = AW'(wr_row_q) * AW'(TABLE_ROWS) + AW'(wr_col_q);
  assign wdata      = (wr_row_q == '0) ? ((wr_col_q == '0) ? 32'd1 : 32'd0)
                    : rdata + ((wr_col_q == '0) ? 32'd0 : prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_row_q <= '0;
      fill_col_q <= '0;
      wr_en_q    <= 1'b0;
    end else begin
      wr_en_q <= cmd_i.fill_step;
      if (cmd_i.fill_step) begin
        if (32'(fill_col_q) == TABLE_ROWS - 1) begin
          fill_col_q <= '0;
          fill_row_q <= fill_row_q + RW'(1);
        end else begin
          fill_col_q <= fill_col_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_row_q <= fill_row_q;
    wr_col_q <= fill_col_q;
    if (wr_en_q) begin
      prev_q <= rdata;
    end
  end

  // Restoring division step
  assign rem_sh = {rem_q, n_q[31]};
  assign ge     = rem_sh >= {1'b0, base_q};

  // Digit class of the finished remainder and of the top stored digit
  assign new_cls = (rem_q == 32'd0) ? DIG_ZERO : (rem_q == 32'd1) ? DIG_ONE : DIG_BIG;
  assign top_cls = cls_q[MAX_DIGITS-1];

  // Walk: binomial C(m,k) when the count ends here, else C(m-1,k)
  assign take = (top_cls == DIG_BIG) || ((top_cls == DIG_ONE) && (k_q == 6'd1));
  assign mm   = take ? m_q : m_q - MW'(1);
  assign ok   = (top_cls != DIG_ZERO) && (32'(mm) < 32'(TABLE_ROWS))
              && (32'(k_q) < 32'(TABLE_ROWS)) && (32'(k_q) <= 32'(mm));
  assign walk_raddr = AW'(mm) * AW'(TABLE_ROWS) + AW'(k_q);
  assign raddr      = cmd_i.fill_step ? fill_raddr : walk_raddr;

  // Operand, divider and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      lo_q   <= low_bound_i;
      base_q <= base_i;
      kin_q  <= power_count_i;
      n_q    <= high_bound_i;
      pass_q <= 1'b0;
    end
    if (cmd_i.start_pass) begin
      m_q   <= '0;
      acc_q <= '0;
      k_q   <= kin_q;
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(rem_sh - {1'b0, base_q}) : rem_sh[31:0];
      n_q   <= {n_q[30:0], ge};
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.push_digit) begin
      cls_q[MAX_DIGITS-1] <= new_cls;
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        cls_q[i] <= cls_q[i+1];
      end
      m_q <= m_q + MW'(1);
    end
    if (cmd_i.walk_issue) begin
      take_q <= take;
      one_q  <= (top_cls == DIG_ONE);
      ok_q   <= ok;
    end
    if (cmd_i.walk_add) begin
      acc_q <= acc_q + (ok_q ? rdata : 32'd0);
      if (!take_q) begin
        if (one_q) begin
          k_q <= k_q - 6'd1;
        end
        m_q <= m_q - MW'(1);
        cls_q[0] <= DIG_ZERO;
        for (int i = 1; i < MAX_DIGITS; i++) begin
          cls_q[i] <= cls_q[i-1];
        end
      end
    end
    // upper bound done: keep its count, switch to low bound minus one
    if (cmd_i.pass_end && !pass_q) begin
      upper_q <= acc_q;
      n_q     <= lo_q - 32'd1;
      pass_q  <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_count_q <= upper_q - acc_q;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

  // Status
  assign stat_o.fill_last   = (32'(fill_row_q) == TABLE_ROWS - 1)
                            && (32'(fill_col_q) == TABLE_ROWS - 1);
  assign stat_o.base_small  = base_q < 32'd2;
  assign stat_o.div_last    = cnt_q == 5'd31;
  assign stat_o.more_digits = (n_q != 32'd0) && (32'(m_q) + 32'd1 < 32'(MAX_DIGITS));
  assign stat_o.walk_done   = (m_q == '0) || (k_q == 6'd0);
  assign stat_o.take        = take_q;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;
  assign stat_o.pass_lower  = pass_q;

endmodule

/* src/count_sums_of_distinct_powers_top.sv */
// Top level: counts integers in a range that are sums of exactly K distinct powers of B.
//
//  channel  dir  word                                          handshake
//  in_i     in   low_bound, high_bound, power_count, base      valid/ready
//  out_o    out  count                                         valid/ready
//
// One query at a time. Each bound is split into base-B digits by a 32-step serial
// divider, up to 32 digits, then walked from the top with one Pascal table read
// per walk step. After reset the Pascal table RAM is built with in_i.ready low.
// The result sits in an output register; a stalled out_o holds it and the next
// query is taken meanwhile, its result waiting until the register frees.
module count_sums_of_distinct_powers_top #(
  parameter int MAX_DIGITS = 32,
  parameter int TABLE_ROWS = 36
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csdp_in_if.sink    in_i,
  csdp_out_if.source out_o
);
  import csdp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  csdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csdp_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .low_bound_i   (in_i.low_bound),
    .high_bound_i  (in_i.high_bound),
    .power_count_i (in_i.power_count),
    .base_i        (in_i.base),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_count_o   (out_o.count)
  );

endmodule

/* src/csdp_chk.sv */
// Port-level checks on the top level, attached by bind.
module csdp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_count_i
);

  // A word waiting on the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_count_i))
    else $error("output word changed while stalled");

  // One query in flight: no new query right after one is taken
  a_one_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("query taken while another is in flight");

  // A result never appears the cycle after a query is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind count_sums_of_distinct_powers_top csdp_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.count)
);
